>>> hdl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the API frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

   localparam logic [7:0]  DELIMITER       = 8'h7E;
   localparam logic [7:0]  CHECKSUM_BASE   = 8'hFF;
   localparam logic [15:0] MAX_LEN_RESET   = 16'd256;

   localparam int          CSR_ADDR_WIDTH  = 3;
   localparam int          CSR_DATA_WIDTH  = 32;
   localparam logic [0:0]  REG_MAX_LEN     = 1'b0;

   localparam logic [1:0]  STATUS_BUSY     = 2'd0;
   localparam logic [1:0]  STATUS_GOOD     = 2'd1;
   localparam logic [1:0]  STATUS_BAD      = 2'd2;
   localparam logic [1:0]  STATUS_REJECT   = 2'd3;

   typedef struct packed {
      logic [15:0] max_frame_length;
   } afd_cfg_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [15:0] byte_index;
      logic        is_frame_type;
      logic        last;
      logic [1:0]  status;
   } afd_rsp_type;

endpackage

>>> hdl/afd_if.sv
// ----------------------------------------------------------------------------
// afd_if
// Valid/ready channels for received bytes and for deframed result items.
// ----------------------------------------------------------------------------
interface afd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_rsp_if;
   import afd_pkg::*;
   logic        valid;
   logic        ready;
   afd_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/api_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// api_frame_deframer_top
// Streaming receiver for delimited API frames with an 8-bit sum checksum.
//
//   Channel   Direction  Payload
//   req_chan  in         rx_byte
//   rsp_chan  out        byte_value, byte_index, is_frame_type, last, status
//   csr_*     in/out     max_frame_length at byte address 0
//
// One byte is accepted per cycle while the result channel is not stalled.
// The input register feeds the parser, which updates its state and loads the
// result register in the same cycle. Reset clears the parser to hunting and
// sets max_frame_length to 256. A stalled result holds one more byte in the
// input register before req_chan.ready drops.
// ----------------------------------------------------------------------------
module api_frame_deframer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   afd_req_if.sink                              req_chan,
   afd_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [afd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [afd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [afd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import afd_pkg::*;

   afd_cfg_type cfg;

   afd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   afd_frame_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> hdl/afd_csr.sv
// ----------------------------------------------------------------------------
// afd_csr
// APB-style register file holding the maximum accepted frame length.
// ----------------------------------------------------------------------------
module afd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [afd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [afd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [afd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output afd_pkg::afd_cfg_type                 cfg
);
   import afd_pkg::*;

   logic [15:0] max_len_ff;
   logic [15:0] max_len_in;
   logic        reg_sel;

   assign reg_sel    = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_MAX_LEN);
   assign csr_pready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         max_len_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_prdata = reg_sel ? {{(CSR_DATA_WIDTH-16){1'b0}}, max_len_ff} : '0;
   assign cfg.max_frame_length = max_len_ff;

endmodule

>>> hdl/afd_frame_fsm.sv
// ----------------------------------------------------------------------------
// afd_frame_fsm
// Input register, frame parsing state machine and result register.
// ----------------------------------------------------------------------------
module afd_frame_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  afd_pkg::afd_cfg_type cfg,
   afd_req_if.sink              req_chan,
   afd_rsp_if.source            rsp_chan
);
   import afd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_BODY   = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff,  in_byte_in;
   phase_type   phase_ff,    phase_in;
   logic [15:0] length_ff,   length_in;
   logic [15:0] seen_ff,     seen_in;
   logic [7:0]  sum_ff,      sum_in;
   logic        out_valid_ff, out_valid_in;
   afd_rsp_type out_data_ff,  out_data_in;

   logic        advance;
   logic        emit;
   afd_rsp_type result;
   logic [15:0] full_length;
   logic [15:0] seen_next;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign full_length    = {length_ff[15:8], in_byte_ff};
   assign seen_next      = seen_ff + 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      emit      = 1'b0;
      result    = '0;
      unique case (phase_ff)
         PH_LEN_HI: begin
            length_in = {in_byte_ff, 8'h00};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = full_length;
            if (full_length == 16'd0 || full_length > cfg.max_frame_length) begin
               phase_in      = PH_HUNT;
               emit          = 1'b1;
               result.last   = 1'b1;
               result.status = STATUS_REJECT;
            end else begin
               seen_in  = '0;
               sum_in   = '0;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            emit                 = 1'b1;
            result.byte_value    = in_byte_ff;
            result.byte_index    = seen_ff;
            result.is_frame_type = (seen_ff == 16'd0);
            result.status        = STATUS_BUSY;
            sum_in               = sum_ff + in_byte_ff;
            seen_in              = seen_next;
            if (seen_next >= length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            emit              = 1'b1;
            result.byte_index = length_ff;
            result.last       = 1'b1;
            result.status     = ((CHECKSUM_BASE - sum_ff) == in_byte_ff) ?
                                STATUS_GOOD : STATUS_BAD;
            phase_in          = PH_HUNT;
         end
         default: begin
            phase_in = (in_byte_ff == DELIMITER) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = emit;
         out_data_in  = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         length_ff    <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            seen_ff   <= seen_in;
            sum_ff    <= sum_in;
         end
      end
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

>>> hdl/api_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// api_frame_deframer_checker
// Port-level checks on result items of the frame deframer.
// ----------------------------------------------------------------------------
module api_frame_deframer_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input afd_pkg::afd_rsp_type rsp_data
);
   import afd_pkg::*;

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result item changed while stalled");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.status != STATUS_BUSY)))
      else $error("last and final status disagree");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         rsp_data.byte_value == 8'd0 && !rsp_data.is_frame_type)
      else $error("frame end item carries a byte");

   a_type_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_frame_type |->
         rsp_data.byte_index == 16'd0 && rsp_data.status == STATUS_BUSY)
      else $error("frame type byte not at index zero");

endmodule

bind api_frame_deframer_top api_frame_deframer_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
